FILE: hw/rtl/sdmr_pkg.sv
// ============================================================================
// sdmr_pkg
// Shared types, constants and the control-store program of the stereo reverb.
// ============================================================================
package sdmr_pkg;

  localparam int MEMORY_DEPTH_DEF = 32768;
  localparam int SAMPLE_BITS_DEF  = 16;

  localparam int GAIN_W   = 16;   // Q1.15 gains
  localparam int SAMPLE_W = 16;   // port sample fields
  localparam int OFFSET_W = 15;   // tap offsets relative to the write pointer
  localparam int STEP_W   = 6;    // program counter
  localparam int APB_AW   = 5;
  localparam int APB_DW   = 32;
  localparam int NUM_REGS = 8;

  localparam logic [GAIN_W-1:0] HALF_GAIN = 16'd16384;

  // register reset values
  localparam logic [GAIN_W-1:0] IN_GAIN_RST    = 16'd24576;
  localparam logic [GAIN_W-1:0] IIR_GAIN_RST   = 16'd18022;
  localparam logic [GAIN_W-1:0] WALL_GAIN_RST  = 16'd18022;
  localparam logic [GAIN_W-1:0] COMB1_GAIN_RST = 16'd9830;
  localparam logic [GAIN_W-1:0] COMB2_GAIN_RST = 16'd8192;
  localparam logic [GAIN_W-1:0] COMB3_GAIN_RST = 16'd7209;
  localparam logic [GAIN_W-1:0] COMB4_GAIN_RST = 16'd5898;
  localparam logic [GAIN_W-1:0] AP1_GAIN_RST   = 16'd19661;

  // tap offsets: same-side (LS/RS) and cross-side (LX/RX) reflections
  localparam logic [OFFSET_W-1:0] OFF_NONE    = 15'd0;
  localparam logic [OFFSET_W-1:0] OFF_LS_WR   = 15'd32000;
  localparam logic [OFFSET_W-1:0] OFF_LS_PREV = 15'd31999;
  localparam logic [OFFSET_W-1:0] OFF_LS_WALL = 15'd30313;
  localparam logic [OFFSET_W-1:0] OFF_RS_WR   = 15'd24000;
  localparam logic [OFFSET_W-1:0] OFF_RS_PREV = 15'd23999;
  localparam logic [OFFSET_W-1:0] OFF_RS_WALL = 15'd22399;
  localparam logic [OFFSET_W-1:0] OFF_LX_WR   = 15'd16800;
  localparam logic [OFFSET_W-1:0] OFF_LX_PREV = 15'd16799;
  localparam logic [OFFSET_W-1:0] OFF_LX_WALL = 15'd8967;
  localparam logic [OFFSET_W-1:0] OFF_RX_WR   = 15'd10400;
  localparam logic [OFFSET_W-1:0] OFF_RX_PREV = 15'd10399;
  localparam logic [OFFSET_W-1:0] OFF_RX_WALL = 15'd15301;
  // early echo combs
  localparam logic [OFFSET_W-1:0] OFF_LC1 = 15'd31647;
  localparam logic [OFFSET_W-1:0] OFF_LC2 = 15'd31063;
  localparam logic [OFFSET_W-1:0] OFF_LC3 = 15'd16127;
  localparam logic [OFFSET_W-1:0] OFF_LC4 = 15'd15613;
  localparam logic [OFFSET_W-1:0] OFF_RC1 = 15'd23599;
  localparam logic [OFFSET_W-1:0] OFF_RC2 = 15'd23119;
  localparam logic [OFFSET_W-1:0] OFF_RC3 = 15'd9783;
  localparam logic [OFFSET_W-1:0] OFF_RC4 = 15'd9271;
  // all-pass writers and their delayed reads
  localparam logic [OFFSET_W-1:0] OFF_LA1_WR = 15'd5600;
  localparam logic [OFFSET_W-1:0] OFF_LA1_RD = 15'd4549;
  localparam logic [OFFSET_W-1:0] OFF_RA1_WR = 15'd4400;
  localparam logic [OFFSET_W-1:0] OFF_RA1_RD = 15'd3349;
  localparam logic [OFFSET_W-1:0] OFF_LA2_WR = 15'd3200;
  localparam logic [OFFSET_W-1:0] OFF_LA2_RD = 15'd2613;
  localparam logic [OFFSET_W-1:0] OFF_RA2_WR = 15'd2400;
  localparam logic [OFFSET_W-1:0] OFF_RA2_RD = 15'd1813;

  localparam logic [STEP_W-1:0] START_STEP = '0;

  typedef enum logic [2:0] {
    REG_IN_GAIN, REG_IIR_GAIN, REG_WALL_GAIN, REG_COMB_GAIN_ONE,
    REG_COMB_GAIN_TWO, REG_COMB_GAIN_THREE, REG_COMB_GAIN_FOUR, REG_ALLPASS_GAIN_ONE
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] in_gain;
    logic [GAIN_W-1:0] iir_gain;
    logic [GAIN_W-1:0] wall_gain;
    logic [GAIN_W-1:0] comb_gain_one;
    logic [GAIN_W-1:0] comb_gain_two;
    logic [GAIN_W-1:0] comb_gain_three;
    logic [GAIN_W-1:0] comb_gain_four;
    logic [GAIN_W-1:0] allpass_gain_one;
  } gains_t;

  // multiplier gain operand
  typedef enum logic [3:0] {
    G_IN, G_IIR, G_WALL, G_C1, G_C2, G_C3, G_C4, G_AP1, G_HALF
  } gsel_t;

  // multiplier sample operand
  typedef enum logic [2:0] {
    M_IN_L, M_IN_R, M_RDATA, M_ACC, M_DLY, M_SATACC
  } msel_t;

  // capture of memory read data
  typedef enum logic [1:0] {
    LD_NONE, LD_PREV, LD_DLY
  } ld_t;

  // accumulator / result operations on the registered product
  typedef enum logic [3:0] {
    OP_NONE,    // no register update
    OP_LIN,     // lin = sat(rnd(prod))
    OP_RIN,     // rin = sat(rnd(prod))
    OP_REFL_L,  // acc = lin + rnd(prod) - prev
    OP_REFL_R,  // acc = rin + rnd(prod) - prev
    OP_WOUT,    // acc = rnd(prod) + prev
    OP_CLR,     // acc = 0
    OP_ADD,     // acc += prod
    OP_XRND,    // x = rnd(acc)
    OP_AP_A,    // acc = x - rnd(prod)
    OP_AP_X,    // x = rnd(prod) + dly
    OP_OUTL,    // hold left result
    OP_FIN      // load output register, advance pointer
  } op_t;

  typedef enum logic [1:0] {
    JMP_NEXT, JMP_WAIT_IN, JMP_WAIT_OUT, JMP_RESTART
  } jmp_t;

  typedef struct packed {
    logic                rd_en;
    logic [OFFSET_W-1:0] rd_off;
    logic                wr_en;
    logic [OFFSET_W-1:0] wr_off;
    gsel_t               gsel;
    msel_t               msel;
    ld_t                 ld;
    op_t                 op;
    jmp_t                jmp;
  } ctrl_word_t;

  typedef struct packed {
    logic in_fire;
    logic out_free;
  } seq_status_t;

  typedef struct packed {
    logic clearing;
    logic out_free;
  } dp_status_t;

  function automatic ctrl_word_t uw(input logic rd_en, input logic [OFFSET_W-1:0] rd_off,
                                    input logic wr_en, input logic [OFFSET_W-1:0] wr_off,
                                    input gsel_t gsel, input msel_t msel, input ld_t ld,
                                    input op_t op, input jmp_t jmp);
    ctrl_word_t w;
    w.rd_en  = rd_en;
    w.rd_off = rd_off;
    w.wr_en  = wr_en;
    w.wr_off = wr_off;
    w.gsel   = gsel;
    w.msel   = msel;
    w.ld     = ld;
    w.op     = op;
    w.jmp    = jmp;
    return w;
  endfunction

  // Program: read data lands in the step after the read, the product in the
  // step after the multiply, and ops consume the product in that step.
  function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    unique case (step)
      // wait for a sample pair
      6'd0:  w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_IN, M_IN_L, LD_NONE, OP_NONE, JMP_WAIT_IN);
      // input gain, left same-side reflection
      6'd1:  w = uw(1'b1, OFF_LS_PREV, 1'b0, OFF_NONE, G_IN, M_IN_L, LD_NONE, OP_NONE, JMP_NEXT);
      6'd2:  w = uw(1'b1, OFF_LS_WALL, 1'b0, OFF_NONE, G_IN, M_IN_R, LD_PREV, OP_LIN, JMP_NEXT);
      6'd3:  w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_WALL, M_RDATA, LD_NONE, OP_RIN, JMP_NEXT);
      6'd4:  w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_IIR, M_ACC, LD_NONE, OP_REFL_L, JMP_NEXT);
      6'd5:  w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_IIR, M_ACC, LD_NONE, OP_NONE, JMP_NEXT);
      6'd6:  w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_IIR, M_ACC, LD_NONE, OP_WOUT, JMP_NEXT);
      // right same-side reflection
      6'd7:  w = uw(1'b1, OFF_RS_PREV, 1'b1, OFF_LS_WR, G_IIR, M_ACC, LD_NONE, OP_NONE, JMP_NEXT);
      6'd8:  w = uw(1'b1, OFF_RS_WALL, 1'b0, OFF_NONE, G_IIR, M_ACC, LD_PREV, OP_NONE, JMP_NEXT);
      6'd9:  w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_WALL, M_RDATA, LD_NONE, OP_NONE, JMP_NEXT);
      6'd10: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_IIR, M_ACC, LD_NONE, OP_REFL_R, JMP_NEXT);
      6'd11: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_IIR, M_ACC, LD_NONE, OP_NONE, JMP_NEXT);
      6'd12: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_IIR, M_ACC, LD_NONE, OP_WOUT, JMP_NEXT);
      // left cross-side reflection
      6'd13: w = uw(1'b1, OFF_LX_PREV, 1'b1, OFF_RS_WR, G_IIR, M_ACC, LD_NONE, OP_NONE, JMP_NEXT);
      6'd14: w = uw(1'b1, OFF_LX_WALL, 1'b0, OFF_NONE, G_IIR, M_ACC, LD_PREV, OP_NONE, JMP_NEXT);
      6'd15: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_WALL, M_RDATA, LD_NONE, OP_NONE, JMP_NEXT);
      6'd16: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_IIR, M_ACC, LD_NONE, OP_REFL_L, JMP_NEXT);
      6'd17: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_IIR, M_ACC, LD_NONE, OP_NONE, JMP_NEXT);
      6'd18: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_IIR, M_ACC, LD_NONE, OP_WOUT, JMP_NEXT);
      // right cross-side reflection
      6'd19: w = uw(1'b1, OFF_RX_PREV, 1'b1, OFF_LX_WR, G_IIR, M_ACC, LD_NONE, OP_NONE, JMP_NEXT);
      6'd20: w = uw(1'b1, OFF_RX_WALL, 1'b0, OFF_NONE, G_IIR, M_ACC, LD_PREV, OP_NONE, JMP_NEXT);
      6'd21: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_WALL, M_RDATA, LD_NONE, OP_NONE, JMP_NEXT);
      6'd22: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_IIR, M_ACC, LD_NONE, OP_REFL_R, JMP_NEXT);
      6'd23: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_IIR, M_ACC, LD_NONE, OP_NONE, JMP_NEXT);
      6'd24: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_IIR, M_ACC, LD_NONE, OP_WOUT, JMP_NEXT);
      // left combs
      6'd25: w = uw(1'b1, OFF_LC1, 1'b1, OFF_RX_WR, G_C1, M_RDATA, LD_NONE, OP_CLR, JMP_NEXT);
      6'd26: w = uw(1'b1, OFF_LC2, 1'b0, OFF_NONE, G_C1, M_RDATA, LD_NONE, OP_NONE, JMP_NEXT);
      6'd27: w = uw(1'b1, OFF_LC3, 1'b0, OFF_NONE, G_C2, M_RDATA, LD_NONE, OP_ADD, JMP_NEXT);
      6'd28: w = uw(1'b1, OFF_LC4, 1'b0, OFF_NONE, G_C3, M_RDATA, LD_NONE, OP_ADD, JMP_NEXT);
      6'd29: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_C4, M_RDATA, LD_NONE, OP_ADD, JMP_NEXT);
      6'd30: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_C4, M_RDATA, LD_NONE, OP_ADD, JMP_NEXT);
      // left first all-pass
      6'd31: w = uw(1'b1, OFF_LA1_RD, 1'b0, OFF_NONE, G_AP1, M_DLY, LD_NONE, OP_XRND, JMP_NEXT);
      6'd32: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_AP1, M_DLY, LD_DLY, OP_NONE, JMP_NEXT);
      6'd33: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_AP1, M_DLY, LD_NONE, OP_NONE, JMP_NEXT);
      6'd34: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_AP1, M_DLY, LD_NONE, OP_AP_A, JMP_NEXT);
      6'd35: w = uw(1'b0, OFF_NONE, 1'b1, OFF_LA1_WR, G_AP1, M_SATACC, LD_NONE, OP_NONE, JMP_NEXT);
      6'd36: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_AP1, M_DLY, LD_NONE, OP_AP_X, JMP_NEXT);
      // left second all-pass
      6'd37: w = uw(1'b1, OFF_LA2_RD, 1'b0, OFF_NONE, G_HALF, M_DLY, LD_NONE, OP_NONE, JMP_NEXT);
      6'd38: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_HALF, M_DLY, LD_DLY, OP_NONE, JMP_NEXT);
      6'd39: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_HALF, M_DLY, LD_NONE, OP_NONE, JMP_NEXT);
      6'd40: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_HALF, M_DLY, LD_NONE, OP_AP_A, JMP_NEXT);
      6'd41: w = uw(1'b0, OFF_NONE, 1'b1, OFF_LA2_WR, G_HALF, M_SATACC, LD_NONE, OP_NONE, JMP_NEXT);
      6'd42: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_HALF, M_DLY, LD_NONE, OP_AP_X, JMP_NEXT);
      // right combs
      6'd43: w = uw(1'b1, OFF_RC1, 1'b0, OFF_NONE, G_C1, M_RDATA, LD_NONE, OP_OUTL, JMP_NEXT);
      6'd44: w = uw(1'b1, OFF_RC2, 1'b0, OFF_NONE, G_C1, M_RDATA, LD_NONE, OP_CLR, JMP_NEXT);
      6'd45: w = uw(1'b1, OFF_RC3, 1'b0, OFF_NONE, G_C2, M_RDATA, LD_NONE, OP_ADD, JMP_NEXT);
      6'd46: w = uw(1'b1, OFF_RC4, 1'b0, OFF_NONE, G_C3, M_RDATA, LD_NONE, OP_ADD, JMP_NEXT);
      6'd47: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_C4, M_RDATA, LD_NONE, OP_ADD, JMP_NEXT);
      6'd48: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_C4, M_RDATA, LD_NONE, OP_ADD, JMP_NEXT);
      // right first all-pass
      6'd49: w = uw(1'b1, OFF_RA1_RD, 1'b0, OFF_NONE, G_AP1, M_DLY, LD_NONE, OP_XRND, JMP_NEXT);
      6'd50: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_AP1, M_DLY, LD_DLY, OP_NONE, JMP_NEXT);
      6'd51: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_AP1, M_DLY, LD_NONE, OP_NONE, JMP_NEXT);
      6'd52: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_AP1, M_DLY, LD_NONE, OP_AP_A, JMP_NEXT);
      6'd53: w = uw(1'b0, OFF_NONE, 1'b1, OFF_RA1_WR, G_AP1, M_SATACC, LD_NONE, OP_NONE, JMP_NEXT);
      6'd54: w = uw(1'b1, OFF_RA2_RD, 1'b0, OFF_NONE, G_AP1, M_DLY, LD_NONE, OP_AP_X, JMP_NEXT);
      // right second all-pass
      6'd55: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_HALF, M_DLY, LD_DLY, OP_NONE, JMP_NEXT);
      6'd56: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_HALF, M_DLY, LD_NONE, OP_NONE, JMP_NEXT);
      6'd57: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_HALF, M_DLY, LD_NONE, OP_AP_A, JMP_NEXT);
      6'd58: w = uw(1'b0, OFF_NONE, 1'b1, OFF_RA2_WR, G_HALF, M_SATACC, LD_NONE, OP_NONE, JMP_NEXT);
      6'd59: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_HALF, M_DLY, LD_NONE, OP_AP_X, JMP_NEXT);
      // deliver the pair once the output register is free
      6'd60: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_HALF, M_DLY, LD_NONE, OP_FIN, JMP_WAIT_OUT);
      default: w = uw(1'b0, OFF_NONE, 1'b0, OFF_NONE, G_IN, M_IN_L, LD_NONE, OP_NONE,
                      JMP_RESTART);
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/stereo_delay_memory_reverb.sv
// ============================================================================
// stereo_delay_memory_reverb
// Stereo hall reverb on one circular work memory, microcoded datapath.
// ============================================================================
// Usage:
//   s_axis carries one stereo sample pair per transfer; m_axis returns one
//   reverb pair per accepted input, in order. Gains sit in eight APB
//   registers at byte addresses 0x00..0x1C (Q1.15, low 16 bits of pwdata);
//   write them only while the block is idle.
//   The result is loaded into the output register on the last program step;
//   a new pair is taken only on the first step. The 61-step program runs on a
//   single multiplier and a single-port-read work memory, 28 memory accesses.
//   Reset: gains go to their defaults, the write pointer to zero, and the
//   work memory is zeroed by a clearing pass over all MEMORY_DEPTH words
//   (32768 by default) during which s_axis_tready stays low; APB writes are
//   still taken then.
//   Stall: the output register holds a finished pair until m_axis_tready;
//   the next input can be accepted and computed meanwhile, and the program
//   parks on its last step until the output register frees up.
// ============================================================================
module stereo_delay_memory_reverb #(
  parameter int MEMORY_DEPTH = sdmr_pkg::MEMORY_DEPTH_DEF,
  parameter int SAMPLE_BITS  = sdmr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [2*sdmr_pkg::SAMPLE_W-1:0] s_axis_tdata,   // in_left, in_right
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [2*sdmr_pkg::SAMPLE_W-1:0] m_axis_tdata,   // out_left, out_right
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sdmr_pkg::APB_AW-1:0]     paddr,
  input  logic [sdmr_pkg::APB_DW-1:0]     pwdata,
  output logic [sdmr_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);

  sdmr_pkg::gains_t      gains;
  sdmr_pkg::ctrl_word_t  ctrl;
  sdmr_pkg::seq_status_t seq_status;
  sdmr_pkg::dp_status_t  dp_status;
  sdmr_pkg::reg_idx_t    reg_idx;
  logic                  seq_idle;
  logic                  in_fire;
  logic                  cfg_wr;

  // --------------------------------------------------------------------------
  // APB register file: zero wait states, word-aligned registers
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = sdmr_pkg::reg_idx_t'(paddr[sdmr_pkg::APB_AW-1:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.in_gain          <= sdmr_pkg::IN_GAIN_RST;
      gains.iir_gain         <= sdmr_pkg::IIR_GAIN_RST;
      gains.wall_gain        <= sdmr_pkg::WALL_GAIN_RST;
      gains.comb_gain_one    <= sdmr_pkg::COMB1_GAIN_RST;
      gains.comb_gain_two    <= sdmr_pkg::COMB2_GAIN_RST;
      gains.comb_gain_three  <= sdmr_pkg::COMB3_GAIN_RST;
      gains.comb_gain_four   <= sdmr_pkg::COMB4_GAIN_RST;
      gains.allpass_gain_one <= sdmr_pkg::AP1_GAIN_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        sdmr_pkg::REG_IN_GAIN:          gains.in_gain          <= pwdata[15:0];
        sdmr_pkg::REG_IIR_GAIN:         gains.iir_gain         <= pwdata[15:0];
        sdmr_pkg::REG_WALL_GAIN:        gains.wall_gain        <= pwdata[15:0];
        sdmr_pkg::REG_COMB_GAIN_ONE:    gains.comb_gain_one    <= pwdata[15:0];
        sdmr_pkg::REG_COMB_GAIN_TWO:    gains.comb_gain_two    <= pwdata[15:0];
        sdmr_pkg::REG_COMB_GAIN_THREE:  gains.comb_gain_three  <= pwdata[15:0];
        sdmr_pkg::REG_COMB_GAIN_FOUR:   gains.comb_gain_four   <= pwdata[15:0];
        sdmr_pkg::REG_ALLPASS_GAIN_ONE: gains.allpass_gain_one <= pwdata[15:0];
      endcase
    end
  end

  // read back sign-extended
  always_comb begin
    unique case (reg_idx)
      sdmr_pkg::REG_IN_GAIN:
        prdata = sdmr_pkg::APB_DW'($signed(gains.in_gain));
      sdmr_pkg::REG_IIR_GAIN:
        prdata = sdmr_pkg::APB_DW'($signed(gains.iir_gain));
      sdmr_pkg::REG_WALL_GAIN:
        prdata = sdmr_pkg::APB_DW'($signed(gains.wall_gain));
      sdmr_pkg::REG_COMB_GAIN_ONE:
        prdata = sdmr_pkg::APB_DW'($signed(gains.comb_gain_one));
      sdmr_pkg::REG_COMB_GAIN_TWO:
        prdata = sdmr_pkg::APB_DW'($signed(gains.comb_gain_two));
      sdmr_pkg::REG_COMB_GAIN_THREE:
        prdata = sdmr_pkg::APB_DW'($signed(gains.comb_gain_three));
      sdmr_pkg::REG_COMB_GAIN_FOUR:
        prdata = sdmr_pkg::APB_DW'($signed(gains.comb_gain_four));
      sdmr_pkg::REG_ALLPASS_GAIN_ONE:
        prdata = sdmr_pkg::APB_DW'($signed(gains.allpass_gain_one));
    endcase
  end

  // --------------------------------------------------------------------------
  // Input handshake: only while the program waits on its first step and the
  // memory clearing pass is done.
  // --------------------------------------------------------------------------
  assign s_axis_tready = seq_idle & ~dp_status.clearing;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  assign seq_status.in_fire  = in_fire;
  assign seq_status.out_free = dp_status.out_free;

  // sequencer: step counter plus control store
  sdmr_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (seq_status),
    .ctrl   (ctrl),
    .idle   (seq_idle)
  );

  // datapath: work memory, pointer, MAC and output register
  sdmr_dp #(
    .MEMORY_DEPTH (MEMORY_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .gains     (gains),
    .in_fire   (in_fire),
    .in_data   (s_axis_tdata),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .status    (dp_status)
  );

endmodule

FILE: hw/rtl/sdmr_ram.sv
// ============================================================================
// sdmr_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module sdmr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/sdmr_seq.sv
// ============================================================================
// sdmr_seq
// Program counter and control store; issues one control word per cycle.
// ============================================================================
module sdmr_seq (
  input  logic                     clk,
  input  logic                     rst,
  input  sdmr_pkg::seq_status_t    status,
  output sdmr_pkg::ctrl_word_t     ctrl,
  output logic                     idle
);

  logic [sdmr_pkg::STEP_W-1:0] step;
  logic [sdmr_pkg::STEP_W-1:0] step_next;

  assign ctrl = sdmr_pkg::ucode_rom(step);
  assign idle = (ctrl.jmp == sdmr_pkg::JMP_WAIT_IN);

  always_comb begin
    step_next = step;
    unique case (ctrl.jmp)
      sdmr_pkg::JMP_NEXT: begin
        step_next = step + 1'b1;
      end
      sdmr_pkg::JMP_WAIT_IN: begin
        if (status.in_fire) step_next = step + 1'b1;
      end
      sdmr_pkg::JMP_WAIT_OUT: begin
        if (status.out_free) step_next = sdmr_pkg::START_STEP;
      end
      sdmr_pkg::JMP_RESTART: begin
        step_next = sdmr_pkg::START_STEP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= sdmr_pkg::START_STEP;
    end else begin
      step <= step_next;
    end
  end

endmodule

FILE: hw/rtl/sdmr_dp.sv
// ============================================================================
// sdmr_dp
// Datapath: work memory, write pointer, one multiplier, accumulator, output.
// ============================================================================
module sdmr_dp #(
  parameter int MEMORY_DEPTH = sdmr_pkg::MEMORY_DEPTH_DEF,
  parameter int SAMPLE_BITS  = sdmr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  sdmr_pkg::ctrl_word_t            ctrl,
  input  sdmr_pkg::gains_t                gains,
  input  logic                            in_fire,
  input  logic [2*sdmr_pkg::SAMPLE_W-1:0] in_data,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [2*sdmr_pkg::SAMPLE_W-1:0] out_data,
  output sdmr_pkg::dp_status_t            status
);

  localparam int ADDR_W = $clog2(MEMORY_DEPTH);
  localparam int W      = SAMPLE_BITS;
  localparam int SW     = sdmr_pkg::SAMPLE_W;
  localparam int GW     = sdmr_pkg::GAIN_W;
  // reflection difference needs W+2 bits; one spare
  localparam int MOP_W  = (W + 3 > SW) ? W + 3 : SW;
  localparam int PROD_W = GW + MOP_W;
  localparam int ACC_W  = PROD_W + 1;

  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(16384);
  localparam logic signed [ACC_W-1:0] SAT_HI   = (ACC_W'(1) <<< (W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_LO   = -SAT_HI - ACC_W'(1);

  // round half up, then drop the Q15 fraction
  function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] y;
    y = x + RND_BIAS;
    return y >>> 15;
  endfunction

  function automatic logic signed [W-1:0] sat(input logic signed [ACC_W-1:0] x);
    logic signed [W-1:0] r;
    if (x > SAT_HI) r = SAT_HI[W-1:0];
    else if (x < SAT_LO) r = SAT_LO[W-1:0];
    else r = x[W-1:0];
    return r;
  endfunction

  // pointer and clearing pass
  logic [ADDR_W-1:0] ptr;
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  // operands and working registers
  logic signed [SW-1:0]     in_l, in_r;
  logic signed [W-1:0]      lin, rin, prev, dly, outl;
  logic signed [ACC_W-1:0]  acc, xv;
  logic signed [PROD_W-1:0] prod;
  logic [SW-1:0]            out_left, out_right;

  logic signed [GW-1:0]     gain_val;
  logic signed [MOP_W-1:0]  mop_val;
  logic signed [ACC_W-1:0]  prodx, prod_rnd;
  logic signed [W-1:0]      acc_sat, xv_sat, rdata_s;
  logic [W-1:0]             rdata;
  logic [W-1:0]             wdata;
  logic [ADDR_W-1:0]        raddr, waddr;
  logic                     we;
  logic                     out_free;
  logic                     fin_fire;

  assign prodx    = ACC_W'(prod);
  assign prod_rnd = rnd(prodx);
  assign acc_sat  = sat(acc);
  assign xv_sat   = sat(xv);
  assign rdata_s  = $signed(rdata);

  assign out_free = ~out_valid | out_ready;
  assign fin_fire = (ctrl.op == sdmr_pkg::OP_FIN) & out_free;

  assign raddr = ptr + ADDR_W'(ctrl.rd_off);
  assign waddr = clearing ? clr_addr : ptr + ADDR_W'(ctrl.wr_off);
  assign wdata = clearing ? '0 : acc_sat;
  assign we    = clearing | ctrl.wr_en;

  sdmr_ram #(
    .WIDTH (W),
    .DEPTH (MEMORY_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ctrl.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    unique case (ctrl.gsel)
      sdmr_pkg::G_IN:   gain_val = $signed(gains.in_gain);
      sdmr_pkg::G_IIR:  gain_val = $signed(gains.iir_gain);
      sdmr_pkg::G_WALL: gain_val = $signed(gains.wall_gain);
      sdmr_pkg::G_C1:   gain_val = $signed(gains.comb_gain_one);
      sdmr_pkg::G_C2:   gain_val = $signed(gains.comb_gain_two);
      sdmr_pkg::G_C3:   gain_val = $signed(gains.comb_gain_three);
      sdmr_pkg::G_C4:   gain_val = $signed(gains.comb_gain_four);
      sdmr_pkg::G_AP1:  gain_val = $signed(gains.allpass_gain_one);
      sdmr_pkg::G_HALF: gain_val = $signed(sdmr_pkg::HALF_GAIN);
      default:          gain_val = '0;
    endcase
  end

  always_comb begin
    unique case (ctrl.msel)
      sdmr_pkg::M_IN_L:   mop_val = MOP_W'(in_l);
      sdmr_pkg::M_IN_R:   mop_val = MOP_W'(in_r);
      sdmr_pkg::M_RDATA:  mop_val = MOP_W'(rdata_s);
      sdmr_pkg::M_ACC:    mop_val = $signed(acc[MOP_W-1:0]);
      sdmr_pkg::M_DLY:    mop_val = MOP_W'(dly);
      sdmr_pkg::M_SATACC: mop_val = MOP_W'(acc_sat);
      default:            mop_val = '0;
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    prod <= gain_val * mop_val;
    if (in_fire) begin
      in_l <= $signed(in_data[SW-1:0]);
      in_r <= $signed(in_data[2*SW-1:SW]);
    end
    unique case (ctrl.ld)
      sdmr_pkg::LD_PREV: prev <= rdata_s;
      sdmr_pkg::LD_DLY:  dly  <= rdata_s;
      default: ;
    endcase
    unique case (ctrl.op)
      sdmr_pkg::OP_LIN:    lin  <= sat(prod_rnd);
      sdmr_pkg::OP_RIN:    rin  <= sat(prod_rnd);
      sdmr_pkg::OP_REFL_L: acc  <= ACC_W'(lin) + prod_rnd - ACC_W'(prev);
      sdmr_pkg::OP_REFL_R: acc  <= ACC_W'(rin) + prod_rnd - ACC_W'(prev);
      sdmr_pkg::OP_WOUT:   acc  <= prod_rnd + ACC_W'(prev);
      sdmr_pkg::OP_CLR:    acc  <= '0;
      sdmr_pkg::OP_ADD:    acc  <= acc + prodx;
      sdmr_pkg::OP_XRND:   xv   <= rnd(acc);
      sdmr_pkg::OP_AP_A:   acc  <= xv - prod_rnd;
      sdmr_pkg::OP_AP_X:   xv   <= prod_rnd + ACC_W'(dly);
      sdmr_pkg::OP_OUTL:   outl <= xv_sat;
      default: ;
    endcase
    if (fin_fire) begin
      out_left  <= SW'(outl);
      out_right <= SW'(xv_sat);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      clearing  <= 1'b1;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (&clr_addr) clearing <= 1'b0;
      end
      if (fin_fire) begin
        ptr       <= ptr + 1'b1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_data        = {out_right, out_left};
  assign status.clearing = clearing;
  assign status.out_free = out_free;

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Stereo reverb testbench
// Streams sample pairs into the reverb, predicts every output pair with an
// independent fixed-point model of the reverb network and its work memory,
// and checks each output transfer in order under random gain settings, bursty
// input and a receiver that stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module testbench;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 4;
  localparam int MEM_WORDS    = 32768;
  localparam int TICK_LATENCY = 64;     // program length plus some slack
  localparam int HOLD_CYCLES  = 600;    // long receiver hold-off
  localparam int STALL_LIMIT  = 150000; // covers the clearing pass after reset
  localparam int MAX_REPORTS  = 10;

  // Network taps, relative to the write pointer.
  localparam int LS_WR = 32000, LS_WALL = 30313;
  localparam int RS_WR = 24000, RS_WALL = 22399;
  localparam int LX_WR = 16800, LX_WALL = 8967;
  localparam int RX_WR = 10400, RX_WALL = 15301;
  localparam int LC1 = 31647, LC2 = 31063, LC3 = 16127, LC4 = 15613;
  localparam int RC1 = 23599, RC2 = 23119, RC3 = 9783,  RC4 = 9271;
  localparam int LA1_WR = 5600, RA1_WR = 4400, AP1_DELAY = 1051;
  localparam int LA2_WR = 3200, RA2_WR = 2400, AP2_DELAY = 587;
  localparam longint AP2_GAIN = 16384;  // second all-pass stays at one half

  localparam logic [15:0] DEFAULT_GAINS [sdmr_pkg::NUM_REGS] =
    '{16'd24576, 16'd18022, 16'd18022, 16'd9830, 16'd8192, 16'd7209, 16'd5898, 16'd19661};

  // left sits in the low half of tdata
  typedef struct packed {
    logic signed [15:0] right;
    logic signed [15:0] left;
  } stereo_pair_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;    // in_left [15:0], in_right [31:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;    // out_left [15:0], out_right [31:16]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  stereo_delay_memory_reverb dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Reverb predictor: own copy of the work memory, pointer and gains.
  // --------------------------------------------------------------------------
  logic signed [15:0] echo_mem [MEM_WORDS];
  logic [14:0]        wr_ptr;
  logic signed [15:0] gain_q15 [sdmr_pkg::NUM_REGS];

  stereo_pair_t expected_out [$];
  int  in_count   = 0;
  int  mismatches = 0;
  bit  hold_off_req = 1'b0;
  int  burst_left = 0;

  // Q1.15 rounding: floor((x + 2^14) / 2^15), arithmetic shift is the floor
  function automatic longint rnd_q15(longint x);
    return (x + 64'sd16384) >>> 15;
  endfunction

  function automatic logic signed [15:0] sat16(longint x);
    if (x > 32767) return 16'sh7fff;
    if (x < -32768) return 16'sh8000;
    return x[15:0];
  endfunction

  function automatic logic [14:0] tap(int off);
    return wr_ptr + off[14:0];
  endfunction

  function automatic longint mem_at(int off);
    return longint'(echo_mem[tap(off)]);
  endfunction

  function automatic longint gain_of(sdmr_pkg::reg_idx_t idx);
    return longint'(gain_q15[idx]);
  endfunction

  // one-pole smoothed wall reflection
  function automatic void reflect(int writer, int wall, longint in_s);
    longint prev, t;
    prev = mem_at(writer - 1);
    t = in_s + rnd_q15(gain_of(sdmr_pkg::REG_WALL_GAIN) * mem_at(wall)) - prev;
    echo_mem[tap(writer)] = sat16(rnd_q15(gain_of(sdmr_pkg::REG_IIR_GAIN) * t) + prev);
  endfunction

  // the saturated stored value feeds the forward path
  function automatic longint allpass_stage(longint x, int writer, int delay, longint g,
                                           bit last);
    longint d;
    logic signed [15:0] a;
    d = mem_at(writer - delay);
    a = sat16(x - rnd_q15(g * d));
    echo_mem[tap(writer)] = a;
    x = rnd_q15(g * longint'(a)) + d;
    return last ? longint'(sat16(x)) : x;
  endfunction

  function automatic longint comb_sum(int o1, int o2, int o3, int o4);
    return rnd_q15(gain_of(sdmr_pkg::REG_COMB_GAIN_ONE) * mem_at(o1)
                 + gain_of(sdmr_pkg::REG_COMB_GAIN_TWO) * mem_at(o2)
                 + gain_of(sdmr_pkg::REG_COMB_GAIN_THREE) * mem_at(o3)
                 + gain_of(sdmr_pkg::REG_COMB_GAIN_FOUR) * mem_at(o4));
  endfunction

  function automatic stereo_pair_t reverb_tick(logic signed [15:0] in_l,
                                               logic signed [15:0] in_r);
    longint lin, rin, l, r;
    stereo_pair_t res;
    lin = sat16(rnd_q15(gain_of(sdmr_pkg::REG_IN_GAIN) * longint'(in_l)));
    rin = sat16(rnd_q15(gain_of(sdmr_pkg::REG_IN_GAIN) * longint'(in_r)));
    reflect(LS_WR, LS_WALL, lin);
    reflect(RS_WR, RS_WALL, rin);
    reflect(LX_WR, LX_WALL, lin);
    reflect(RX_WR, RX_WALL, rin);
    l = comb_sum(LC1, LC2, LC3, LC4);
    r = comb_sum(RC1, RC2, RC3, RC4);
    l = allpass_stage(l, LA1_WR, AP1_DELAY, gain_of(sdmr_pkg::REG_ALLPASS_GAIN_ONE), 1'b0);
    r = allpass_stage(r, RA1_WR, AP1_DELAY, gain_of(sdmr_pkg::REG_ALLPASS_GAIN_ONE), 1'b0);
    l = allpass_stage(l, LA2_WR, AP2_DELAY, AP2_GAIN, 1'b1);
    r = allpass_stage(r, RA2_WR, AP2_DELAY, AP2_GAIN, 1'b1);
    wr_ptr = wr_ptr + 15'd1;
    res.left  = l[15:0];
    res.right = r[15:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Monitors, sampled at the rising edge (inputs move on the falling edge).
  // --------------------------------------------------------------------------
  // every accepted input pair yields exactly one expected output pair
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      expected_out.push_back(reverb_tick(s_axis_tdata[15:0], s_axis_tdata[31:16]));
      in_count++;
    end
  end

  always @(posedge clk) begin : result_check
    stereo_pair_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_out.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected output transfer: left %0d right %0d", got.left, got.right);
      end else begin
        want = expected_out.pop_front();
        if (got.left !== want.left || got.right !== want.right) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("output mismatch: left exp %0d got %0d, right exp %0d got %0d",
                     want.left, got.left, want.right, got.right);
        end
      end
    end
  end

  // no-progress watchdog: counts cycles with no transfer on either stream
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", quiet);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver pacing: stretches of always-ready, coin-flip and mostly-stalled,
  // plus one long hold-off on request.
  // --------------------------------------------------------------------------
  initial begin : out_pacing
    int stretch;
    int mode;
    stretch = 0;
    mode = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_off_req = 1'b0;
        stretch = 0;
      end else begin
        if (stretch == 0) begin
          mode = $urandom_range(0, 2);
          stretch = $urandom_range(16, 400);
        end
        stretch--;
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= $urandom_range(0, 1);
          default: m_axis_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks; all are entered and left on a falling edge.
  // --------------------------------------------------------------------------
  // offer one pair after an optional gap, return once it is accepted
  task automatic send_pair(logic [15:0] in_l, logic [15:0] in_r, int gap);
    int target;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {in_r, in_l};
    target = in_count + 1;
    do @(negedge clk); while (in_count < target);
  endtask

  // sender pause: everything predicted has come out, block is idle again
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_out.size() != 0) @(negedge clk);
    repeat (TICK_LATENCY) @(negedge clk);
  endtask

  // APB write: setup then access; upper data bits are don't-care
  task automatic write_gain(sdmr_pkg::reg_idx_t idx, logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom()), value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    gain_q15[idx] = value;
    @(negedge clk);
  endtask

  task automatic write_all_gains(logic [15:0] value);
    for (int i = 0; i < sdmr_pkg::NUM_REGS; i++) write_gain(sdmr_pkg::reg_idx_t'(i), value);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 512) - 256);
      default: return 16'($urandom());
    endcase
  endfunction

  // mostly moderate gains, sometimes anything the register holds
  function automatic logic [15:0] rand_gain();
    if ($urandom_range(0, 3) == 0) return 16'($urandom());
    return 16'($urandom_range(0, 32767) - 16384);
  endfunction

  // bursts of back-to-back transfers separated by random gaps
  function automatic int next_gap(bit bursty);
    int gap;
    gap = 0;
    if (bursty && burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(61, 250) : $urandom_range(1, 70);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    return gap;
  endfunction

  task automatic stream_random(int count, bit bursty);
    for (int i = 0; i < count; i++) send_pair(rand_sample(), rand_sample(), next_gap(bursty));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // sample extremes at reset gains, first ones are offered during the clearing pass
  task automatic test_directed_samples();
    logic [15:0] lefts  [10] = '{16'h0000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                                16'h0001, 16'hffff, 16'h5555, 16'haaaa, 16'h0000};
    logic [15:0] rights [10] = '{16'h0000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                                16'hffff, 16'h0001, 16'haaaa, 16'h5555, 16'h0000};
    for (int i = 0; i < 10; i++)
      send_pair(lefts[i], rights[i], (i % 3 == 2) ? $urandom_range(1, 40) : 0);
    wait_drained();
  endtask

  // stream long enough that the first echoes reach the output
  task automatic test_default_stream();
    stream_random(400, 1'b1);
    wait_drained();
  endtask

  // every register at its extremes; most negative gain times most negative
  // sample must saturate rather than wrap
  task automatic test_gain_extremes();
    write_all_gains(16'h7fff);
    for (int i = 0; i < 8; i++)
      send_pair((i % 2) ? 16'h7fff : 16'h8000, rand_sample(), 0);
    wait_drained();
    write_all_gains(16'h8000);
    for (int i = 0; i < 8; i++)
      send_pair(16'h8000, (i % 2) ? 16'h8000 : rand_sample(), $urandom_range(0, 3));
    wait_drained();
    write_all_gains(16'h0000);
    for (int i = 0; i < 4; i++) send_pair(rand_sample(), rand_sample(), 0);
    wait_drained();
  endtask

  // fresh random gains per phase; phases 1 and 4 use steady pacing, the rest bursty
  task automatic test_random_gains();
    for (int phase = 0; phase < 6; phase++) begin
      for (int i = 0; i < sdmr_pkg::NUM_REGS; i++)
        write_gain(sdmr_pkg::reg_idx_t'(i), rand_gain());
      stream_random(100, phase % 3 != 1);
      wait_drained();
    end
  endtask

  // receiver holds off while the sender keeps offering, so the block parks
  // with a full output register and drops s_axis_tready
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    for (int i = 0; i < 8; i++) send_pair(rand_sample(), rand_sample(), 0);
    wait_drained();
    send_pair(rand_sample(), rand_sample(), 0);
    wait_drained();
  endtask

  task automatic test_default_gains_restored();
    for (int i = 0; i < sdmr_pkg::NUM_REGS; i++)
      write_gain(sdmr_pkg::reg_idx_t'(i), DEFAULT_GAINS[i]);
    stream_random(60, 1'b1);
    wait_drained();
  endtask

  initial begin
    foreach (echo_mem[i]) echo_mem[i] = '0;
    wr_ptr = '0;
    foreach (gain_q15[i]) gain_q15[i] = DEFAULT_GAINS[i];
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_samples();
    test_default_stream();
    test_gain_extremes();
    test_random_gains();
    test_backpressure();
    test_default_gains_restored();

    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
